// ===== src/bfiq_pkg.sv =====
// constants, types and arithmetic helpers for the bloom filter block
package bfiq_pkg;

    localparam int MAX_BYTES   = 8192;
    localparam int BYTE_W      = $clog2(MAX_BYTES);
    localparam int USED_W      = BYTE_W + 1;
    localparam int NB_W        = BYTE_W + 4;
    localparam int CFG_FB_W    = 14;
    localparam int CFG_NP_W    = 6;
    localparam int HASH_W      = 32;
    localparam int DIV_CNT_W   = $clog2(HASH_W);
    localparam int ROT_RIGHT   = 17;
    localparam int ROT_LEFT    = 15;
    localparam int PROBE_LIMIT = 32;
    localparam int RESET_BYTES = 8192;
    localparam int RESET_PROBES = 6;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic REG_FILTER_BYTES = 1'b0;
    localparam logic REG_NUM_PROBES   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // one restoring remainder step: shift in one dividend bit
    function automatic logic [NB_W-1:0] rem_step(
        input logic [NB_W-1:0] rem,
        input logic            dbit,
        input logic [NB_W-1:0] modulus
    );
        logic [NB_W:0] t;
        t = {rem, dbit};
        if (t >= {1'b0, modulus}) begin
            return NB_W'(t - {1'b0, modulus});
        end
        return NB_W'(t);
    endfunction

    // (a + b) mod n for a, b below n
    function automatic logic [NB_W-1:0] mod_add(
        input logic [NB_W-1:0] a,
        input logic [NB_W-1:0] b,
        input logic [NB_W-1:0] modulus
    );
        logic [NB_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, modulus}) begin
            return NB_W'(s - {1'b0, modulus});
        end
        return NB_W'(s);
    endfunction

    // (a - b) mod n for a, b below n
    function automatic logic [NB_W-1:0] mod_sub(
        input logic [NB_W-1:0] a,
        input logic [NB_W-1:0] b,
        input logic [NB_W-1:0] modulus
    );
        if (a >= b) begin
            return a - b;
        end
        return NB_W'({1'b0, a} + {1'b0, modulus} - {1'b0, b});
    endfunction

endpackage

// ===== src/bloom_filter_insert_query.sv =====
// bloom filter with double hashing over a byte-wide bit store
//
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_ready       i_req_type, i_key_hash, i_key_empty
//  out       source     o_out_valid / i_out_ready     o_maybe_present
//  cfg       apb slave  psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  after reset the store is zeroed one byte a cycle over all MAX_BYTES (8192) bytes, no beat taken
//  an item first runs the bit-serial remainder unit in ST_DIV (hash, step, 2^32 mod bits),
//  then ST_READ and ST_CHECK per probe for the memory read-modify-write, then ST_FINISH to post a query answer
//  a query stops at the first clear bit; an empty-key query skips the probes and goes straight to ST_FINISH
//  a query answer sits in the output register; the next beat is taken while it waits
module bloom_filter_insert_query (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_key_hash,
    input  logic        i_key_empty,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_maybe_present,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfiq_pkg::*;

    t_state r_state, n_state;

    logic [CFG_FB_W-1:0]  r_filter_bytes;
    logic [CFG_NP_W-1:0]  r_num_probes;
    logic [BYTE_W-1:0]    r_clr_addr, n_clr_addr;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_maybe, n_out_maybe;

    logic                 r_query, n_query;
    logic [HASH_W-1:0]    r_h, n_h;
    logic [HASH_W-1:0]    r_delta, n_delta;
    logic [HASH_W-1:0]    r_dh, n_dh;
    logic [HASH_W-1:0]    r_dd, n_dd;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [NB_W-1:0]      r_pos, n_pos;
    logic [NB_W-1:0]      r_dm, n_dm;
    logic [NB_W-1:0]      r_rm, n_rm;
    logic [NB_W-1:0]      r_w, n_w;
    logic [NB_W-1:0]      r_pos_a, n_pos_a;
    logic                 r_wrap, n_wrap;
    logic [CFG_NP_W-1:0]  r_cnt, n_cnt;
    logic                 r_res, n_res;

    logic [7:0]           r_mem [MAX_BYTES];
    logic [7:0]           r_rdata;
    logic                 mem_we;
    logic [BYTE_W-1:0]    mem_waddr;
    logic [7:0]           mem_wdata;
    logic [BYTE_W-1:0]    mem_raddr;

    logic [USED_W-1:0]    used_bytes;
    logic [NB_W-1:0]      modulus;
    logic [CFG_NP_W-1:0]  used_probes;
    logic                 in_beat;
    logic                 out_slot_free;
    logic                 cfg_wr;
    logic [7:0]           probe_mask;
    logic                 probe_hit;
    logic [NB_W-1:0]      rm_inc;
    logic [HASH_W:0]      h_sum;

    assign in_beat       = i_in_valid && o_in_ready;
    assign out_slot_free = !r_out_valid || i_out_ready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_maybe_present = r_out_maybe;
    assign pready        = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_FILTER_BYTES: prdata = 32'(r_filter_bytes);
            REG_NUM_PROBES:   prdata = 32'(r_num_probes);
            default:          prdata = '0;
        endcase
    end

    // clamp configuration to the supported ranges
    always_comb begin
        if (r_filter_bytes == '0) begin
            used_bytes = USED_W'(1);
        end else if (32'(r_filter_bytes) > 32'(MAX_BYTES)) begin
            used_bytes = USED_W'(MAX_BYTES);
        end else begin
            used_bytes = USED_W'(r_filter_bytes);
        end
        if (r_num_probes == '0) begin
            used_probes = CFG_NP_W'(1);
        end else if (32'(r_num_probes) > 32'(PROBE_LIMIT)) begin
            used_probes = CFG_NP_W'(PROBE_LIMIT);
        end else begin
            used_probes = r_num_probes;
        end
    end
    assign modulus = {used_bytes, 3'b000};

    assign probe_mask = 8'(1) << r_pos[2:0];
    assign probe_hit  = (r_rdata & probe_mask) != 8'h00;
    assign rm_inc     = r_rm + NB_W'(1);
    assign h_sum      = {1'b0, r_h} + {1'b0, r_delta};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == BYTE_W'(MAX_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_beat) begin
                    if (i_req_type == REQ_QUERY && i_key_empty) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_query == REQ_QUERY && !probe_hit) begin
                    n_state = ST_FINISH;
                end else if (r_cnt == CFG_NP_W'(1)) begin
                    n_state = (r_query == REQ_QUERY) ? ST_FINISH : ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_FINISH: begin
                if (out_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_maybe = r_out_maybe;
        n_query     = r_query;
        n_h         = r_h;
        n_delta     = r_delta;
        n_dh        = r_dh;
        n_dd        = r_dd;
        n_div_cnt   = r_div_cnt;
        n_pos       = r_pos;
        n_dm        = r_dm;
        n_rm        = r_rm;
        n_w         = r_w;
        n_pos_a     = r_pos_a;
        n_wrap      = r_wrap;
        n_cnt       = r_cnt;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[BYTE_W+2:3];
        mem_wdata   = r_rdata | probe_mask;
        mem_raddr   = r_pos[BYTE_W+2:3];
        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = 8'h00;
                n_clr_addr = r_clr_addr + BYTE_W'(1);
            end
            ST_IDLE: begin
                if (in_beat) begin
                    n_query   = i_req_type;
                    n_h       = i_key_hash;
                    n_delta   = {i_key_hash[ROT_RIGHT-1:0], i_key_hash[HASH_W-1:ROT_RIGHT]};
                    n_dh      = i_key_hash;
                    n_dd      = {i_key_hash[ROT_RIGHT-1:0], i_key_hash[HASH_W-1:ROT_RIGHT]};
                    n_pos     = '0;
                    n_dm      = '0;
                    n_rm      = '0;
                    n_div_cnt = DIV_CNT_W'(HASH_W - 1);
                    n_cnt     = used_probes;
                    n_res     = 1'b0;
                end
            end
            ST_DIV: begin
                // three remainder lanes, msb first: hash, step, and all ones
                n_pos     = rem_step(r_pos, r_dh[HASH_W-1], modulus);
                n_dm      = rem_step(r_dm, r_dd[HASH_W-1], modulus);
                n_rm      = rem_step(r_rm, 1'b1, modulus);
                n_dh      = {r_dh[HASH_W-2:0], 1'b0};
                n_dd      = {r_dd[HASH_W-2:0], 1'b0};
                n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
            end
            ST_READ: begin
                n_pos_a = mod_add(r_pos, r_dm, modulus);
                n_wrap  = h_sum[HASH_W];
                n_h     = h_sum[HASH_W-1:0];
                // 2^32 mod n from (2^32 - 1) mod n
                n_w     = (rm_inc == modulus) ? '0 : rm_inc;
            end
            ST_CHECK: begin
                if (r_query == REQ_QUERY) begin
                    if (!probe_hit) begin
                        n_res = 1'b0;
                    end else begin
                        n_res = 1'b1;
                    end
                end else begin
                    mem_we = 1'b1;
                end
                n_cnt = r_cnt - CFG_NP_W'(1);
                // the 32-bit wrap of the running hash drops 2^32 from it
                n_pos = r_wrap ? mod_sub(r_pos_a, r_w, modulus) : r_pos_a;
            end
            ST_FINISH: begin
                if (out_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_maybe = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
            r_filter_bytes <= CFG_FB_W'(RESET_BYTES);
            r_num_probes   <= CFG_NP_W'(RESET_PROBES);
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_FILTER_BYTES: r_filter_bytes <= pwdata[CFG_FB_W-1:0];
                    REG_NUM_PROBES:   r_num_probes   <= pwdata[CFG_NP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_maybe <= n_out_maybe;
        r_query     <= n_query;
        r_h         <= n_h;
        r_delta     <= n_delta;
        r_dh        <= n_dh;
        r_dd        <= n_dd;
        r_div_cnt   <= n_div_cnt;
        r_pos       <= n_pos;
        r_dm        <= n_dm;
        r_rm        <= n_rm;
        r_w         <= n_w;
        r_pos_a     <= n_pos_a;
        r_wrap      <= n_wrap;
        r_cnt       <= n_cnt;
        r_res       <= n_res;
    end

    // bit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

// ===== test/tb_top.sv =====
// testbench for the bloom filter block: directed and random insert/query beats against a shadow store
module tb_top;
    import bfiq_pkg::*;

    localparam int QUIET_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 150;
    localparam int KEEP_KEYS     = 64;
    localparam logic [2:0] ADDR_FILTER_BYTES = {REG_FILTER_BYTES, 2'b00};
    localparam logic [2:0] ADDR_NUM_PROBES   = {REG_NUM_PROBES, 2'b00};

    typedef struct {
        logic [31:0] hash;
        logic        present;
    } t_answer;

    // shadow copy of the filter: same store, same registers, queue of pending query answers
    class bloom_shadow;
        bit [7:0]          store_bytes [MAX_BYTES];
        bit [CFG_FB_W-1:0] size_reg;
        bit [CFG_NP_W-1:0] probes_reg;
        t_answer           answers_due[$];
        int                errors;

        function new();
            size_reg   = CFG_FB_W'(RESET_BYTES);
            probes_reg = CFG_NP_W'(RESET_PROBES);
            errors     = 0;
        endfunction

        function void report(string msg);
            if (errors < 50) begin
                $display("mismatch: %s", msg);
            end
            errors++;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == REG_FILTER_BYTES) begin
                size_reg = value[CFG_FB_W-1:0];
            end else begin
                probes_reg = value[CFG_NP_W-1:0];
            end
        endfunction

        // accepted beat: walk the probe sequence, set bits or test them
        function void take_key(logic req, logic [31:0] hash, logic empty);
            int unsigned nbytes;
            int unsigned nbits;
            int unsigned nprobes;
            bit [31:0]   h;
            bit [31:0]   step;
            bit [31:0]   pos;
            bit          hit;
            t_answer     ans;
            nbytes  = (size_reg == 0) ? 1 : (size_reg > MAX_BYTES) ? MAX_BYTES : size_reg;
            nprobes = (probes_reg == 0) ? 1 : (probes_reg > PROBE_LIMIT) ? PROBE_LIMIT
                                                                         : probes_reg;
            nbits = nbytes * 8;
            h     = hash;
            step  = (h >> ROT_RIGHT) | (h << ROT_LEFT);
            hit   = 1'b1;
            ans.hash = hash;
            if (req == REQ_QUERY && empty) begin
                ans.present = 1'b0;
                answers_due.push_back(ans);
                return;
            end
            for (int j = 0; j < nprobes && hit; j++) begin
                pos = h % nbits;
                if (req == REQ_QUERY) begin
                    hit = store_bytes[pos >> 3][pos[2:0]];
                end else begin
                    store_bytes[pos >> 3][pos[2:0]] = 1'b1;
                end
                h = h + step;
            end
            if (req == REQ_QUERY) begin
                ans.present = hit;
                answers_due.push_back(ans);
            end
        endfunction

        function void check_answer(logic got);
            t_answer want;
            if (answers_due.size() == 0) begin
                report($sformatf("answer %0b with no query pending", got));
                return;
            end
            want = answers_due.pop_front();
            if (got !== want.present) begin
                report($sformatf("hash %08h maybe_present %0b, want %0b",
                                 want.hash, got, want.present));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = REQ_INSERT;
    logic [31:0] i_key_hash = '0;
    logic        i_key_empty = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic        o_maybe_present;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bloom_shadow shadow;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] recent_keys[$];

    bloom_filter_insert_query u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_key_hash     (i_key_hash),
        .i_key_empty    (i_key_empty),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_maybe_present(o_maybe_present),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // answer side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left  <= $urandom_range(1, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                shadow.check_answer(o_maybe_present);
            end
            if (i_in_valid && o_in_ready) begin
                shadow.take_key(i_req_type, i_key_hash, i_key_empty);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("bloom_filter_insert_query regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic drive_key(logic req, logic [31:0] hash, logic empty);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_key_hash  <= hash;
        i_key_empty <= empty;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drain pending answers, then give a trailing insert time to finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (shadow.answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_filter(logic [31:0] nbytes, logic [31:0] nprobes);
        settle();
        write_reg(ADDR_FILTER_BYTES, REG_FILTER_BYTES, nbytes);
        write_reg(ADDR_NUM_PROBES, REG_NUM_PROBES, nprobes);
    endtask

    function automatic logic [31:0] pick_hash();
        case ($urandom_range(0, 19))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_keys(int count);
        logic [31:0] hash;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 45) begin
                hash = pick_hash();
                recent_keys.push_back(hash);
                if (recent_keys.size() > KEEP_KEYS) begin
                    void'(recent_keys.pop_front());
                end
                drive_key(REQ_INSERT, hash, ($urandom_range(0, 7) == 0));
            end else begin
                // mostly ask about keys that went in, so hits show up
                if (recent_keys.size() != 0 && $urandom_range(0, 99) < 60) begin
                    hash = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                end else begin
                    hash = pick_hash();
                end
                drive_key(REQ_QUERY, hash, ($urandom_range(0, 9) == 0));
            end
        end
    endtask

    initial begin
        shadow = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // store clear pass after reset
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);

        gap_pct   = 10;
        stall_pct = 5;
        drive_key(REQ_QUERY, 32'h0000_0000, 1'b0);
        drive_key(REQ_INSERT, 32'h0000_0000, 1'b0);
        drive_key(REQ_QUERY, 32'h0000_0000, 1'b0);
        // empty key still inserts its hash
        drive_key(REQ_INSERT, 32'hFFFF_FFFF, 1'b1);
        drive_key(REQ_QUERY, 32'hFFFF_FFFF, 1'b0);
        drive_key(REQ_QUERY, 32'hFFFF_FFFF, 1'b1);
        drive_key(REQ_QUERY, 32'hA5A5_A5A5, 1'b0);
        drive_key(REQ_INSERT, 32'h8000_0001, 1'b0);
        drive_key(REQ_QUERY, 32'h8000_0001, 1'b0);
        drive_key(REQ_QUERY, 32'h7FFF_FFFE, 1'b0);

        // zero size and zero probes act as one
        set_filter(32'd0, 32'd0);
        drive_key(REQ_INSERT, 32'h0000_0003, 1'b0);
        drive_key(REQ_QUERY, 32'h0000_0003, 1'b0);
        drive_key(REQ_QUERY, 32'h0000_000B, 1'b0);
        drive_key(REQ_QUERY, 32'h0000_0004, 1'b0);

        // register maxima clamp to store size and probe limit
        set_filter(32'd16383, 32'd63);
        drive_key(REQ_INSERT, 32'h1234_5678, 1'b0);
        drive_key(REQ_QUERY, 32'h1234_5678, 1'b0);
        drive_key(REQ_QUERY, 32'h1234_5679, 1'b0);

        // shrinking keeps upper bytes, growing back finds them again
        set_filter(32'd4, 32'd3);
        drive_key(REQ_INSERT, 32'h0000_0005, 1'b0);
        drive_key(REQ_INSERT, 32'h0000_001F, 1'b0);
        set_filter(32'd2, 32'd3);
        drive_key(REQ_QUERY, 32'h0000_0005, 1'b0);
        drive_key(REQ_QUERY, 32'h0000_001F, 1'b0);
        set_filter(32'd4, 32'd3);
        drive_key(REQ_QUERY, 32'h0000_0005, 1'b0);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_filter(RESET_BYTES, RESET_PROBES);
                1: set_filter(32'd1, 32'd1);
                2: set_filter(32'd0, 32'd0);
                3: set_filter(32'd16383, 32'd63);
                4: set_filter(MAX_BYTES, PROBE_LIMIT);
                5: set_filter($urandom_range(1, 64), $urandom_range(1, 8));
                6: set_filter($urandom_range(1, 16383), $urandom_range(0, 63));
                default: set_filter($urandom_range(2, 512), $urandom_range(2, 12));
            endcase
            if (ph == 7 || ph == 3) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(5, 40);
                stall_pct = $urandom_range(2, 10);
            end
            random_keys(216);
        end

        settle();
        if (shadow.answers_due.size() != 0) begin
            shadow.report($sformatf("%0d answers never came", shadow.answers_due.size()));
        end
        if (shadow.errors == 0) begin
            $display("bloom_filter_insert_query regression: pass");
        end else begin
            $display("bloom_filter_insert_query regression: fail");
        end
        $finish;
    end

endmodule
